### rtl/slm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list merge package
// Shared constants, operation codes and transaction types for the merge block.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int DEPTH  = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_APPEND_FIRST  = 2'd0,
      OP_APPEND_SECOND = 2'd1,
      OP_MERGE         = 2'd2,
      OP_UNUSED        = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] merged_value;
      logic               last;
      logic               overflowed;
   } rsp_type;

endpackage

### rtl/sorted_list_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list merge
// Loads two ascending lists of signed values and emits their merged sequence.
// ----------------------------------------------------------------------------
// An append transaction leaves busy low, so appends can be issued back to
// back. A merge transaction first passes a prep state that fetches both list
// heads from the registered-read list memories, then emits one result per
// cycle from the single head comparator until both lists are used up. Each
// result is registered and appears in the cycle after it is picked, valid
// for exactly one cycle on rsp_valid; the receiver cannot stall results. A merge
// of two empty lists produces no result and leaves busy low. On equal
// values the element of the second list is emitted first.
// ----------------------------------------------------------------------------
module sorted_list_merge (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  slm_pkg::req_type req_data,
   output logic             rsp_valid,
   output slm_pkg::rsp_type rsp_data
);

   import slm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PREP = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt1_ff, cnt1_in;
   logic [CNT_W-1:0] cnt2_ff, cnt2_in;
   logic [CNT_W-1:0] idx1_ff, idx1_in;
   logic [CNT_W-1:0] idx2_ff, idx2_in;
   logic        ovf_ff, ovf_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        wr1_en, wr2_en;
   logic [31:0] rd1_data, rd2_data;
   logic        take_first;
   logic        accept;

   slm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (cnt1_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (idx1_in[ADDR_W-1:0]),
      .rd_data (rd1_data)
   );

   slm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (wr2_en),
      .wr_addr (cnt2_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (idx2_in[ADDR_W-1:0]),
      .rd_data (rd2_data)
   );

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign take_first = (idx1_ff < cnt1_ff) &&
                       ((idx2_ff >= cnt2_ff) || ($signed(rd1_data) < $signed(rd2_data)));

   always_comb begin
      state_in     = state_ff;
      cnt1_in      = cnt1_ff;
      cnt2_in      = cnt2_ff;
      idx1_in      = idx1_ff;
      idx2_in      = idx2_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr1_en       = 1'b0;
      wr2_en       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            idx1_in = '0;
            idx2_in = '0;
            if (accept) begin
               case (req_data.operation)
                  OP_APPEND_FIRST: begin
                     if (cnt1_ff < CNT_W'(DEPTH)) begin
                        wr1_en  = 1'b1;
                        cnt1_in = cnt1_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_APPEND_SECOND: begin
                     if (cnt2_ff < CNT_W'(DEPTH)) begin
                        wr2_en  = 1'b1;
                        cnt2_in = cnt2_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_MERGE: begin
                     if ((cnt1_ff == '0) && (cnt2_ff == '0)) begin
                        ovf_in = 1'b0;
                     end else begin
                        state_in = ST_PREP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PREP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.overflowed  = ovf_ff;
            if (take_first) begin
               rsp_data_in.merged_value = $signed(rd1_data);
               idx1_in                  = idx1_ff + 1'b1;
            end else begin
               rsp_data_in.merged_value = $signed(rd2_data);
               idx2_in                  = idx2_ff + 1'b1;
            end
            rsp_data_in.last = (idx1_in == cnt1_ff) && (idx2_in == cnt2_ff);
            if (rsp_data_in.last) begin
               state_in = ST_IDLE;
               cnt1_in  = '0;
               cnt2_in  = '0;
               ovf_in   = 1'b0;
               idx1_in  = '0;
               idx2_in  = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         idx1_ff      <= '0;
         idx2_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         idx1_ff      <= idx1_in;
         idx2_ff      <= idx2_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/slm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module slm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
